// ===== sv/sha256_pkg.sv =====
// Package with SHA-256 constants, shared types and round helper functions.
`default_nettype none
package sha256_pkg;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QueuePtrW = 2;

	// One classified item passed from the front end to the core.
	typedef struct packed {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
	} item_t;

	// Core sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ROUND,
		ST_ADD,
		ST_PAD,
		ST_EMIT
	} core_state_t;

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
		ror = (v >> s) | (v << (32 - s));
	endfunction

	function automatic logic [31:0] small_sigma0(input logic [31:0] x);
		small_sigma0 = ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] small_sigma1(input logic [31:0] x);
		small_sigma1 = ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] big_sigma0(input logic [31:0] x);
		big_sigma0 = ror(x, 2) ^ ror(x, 13) ^ ror(x, 22);
	endfunction

	function automatic logic [31:0] big_sigma1(input logic [31:0] x);
		big_sigma1 = ror(x, 6) ^ ror(x, 11) ^ ror(x, 25);
	endfunction

endpackage
`default_nettype wire

// ===== sv/sha256_front.sv =====
// Front end: takes input beats, drops empty non-final items, queues the rest.
`default_nettype none
module sha256_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,
	input  wire logic                s_tuser,
	input  wire logic                s_tlast,
	output logic                     q_valid,
	input  wire logic                q_pop,
	output sha256_pkg::item_t        q_item
);

	sha256_pkg::item_t mem_q [sha256_pkg::QueueDepth];
	logic [sha256_pkg::QueuePtrW-1:0] wr_ptr_q;
	logic [sha256_pkg::QueuePtrW-1:0] rd_ptr_q;
	logic [sha256_pkg::QueuePtrW:0]   count_q;
	logic push;
	logic take;

	// Beat is taken whenever a slot is free; items with no byte and no end vanish here.
	assign s_tready = (count_q != 3'(sha256_pkg::QueueDepth));
	assign take     = s_tvalid && s_tready;
	assign push     = take && (s_tuser || s_tlast);
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{data: s_tdata, has_byte: s_tuser, last: s_tlast};
		end
	end

	// Queue pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (q_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + {2'b0, push} - {2'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

// ===== sv/sha256_core.sv =====
// Back end: block assembly, padding, 64-round compression and digest output.
`default_nettype none
module sha256_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                q_valid,
	output logic                     q_pop,
	input  wire sha256_pkg::item_t   q_item,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [39:0]              m_tdata,
	output logic                     m_tlast
);

	sha256_pkg::core_state_t state_q, state_d;
	logic [31:0] hash_q [8];
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [60:0] count_q;
	logic [5:0]  round_q;
	logic        final_q;
	logic        pad_done_q;
	logic        tail_q;
	logic [2:0]  emit_idx_q;

	logic [31:0] t1, t2, w_new, w_cur;
	logic        consume;
	logic        block_full;
	logic [5:0]  pos;
	logic        start_rounds;
	logic [63:0] bits;

	assign pos   = count_q[5:0];
	assign w_cur = w_q[0];
	assign w_new = sha256_pkg::small_sigma1(w_q[14]) + w_q[9]
		+ sha256_pkg::small_sigma0(w_q[1]) + w_q[0];
	assign t1 = v_q[7] + sha256_pkg::big_sigma1(v_q[4])
		+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
		+ sha256_pkg::RoundK[round_q] + w_cur;
	assign t2 = sha256_pkg::big_sigma0(v_q[0])
		+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign bits = {count_q, 3'b000};

	// Consume one queued item in idle; a full block or a last flag starts work.
	assign consume    = (state_q == sha256_pkg::ST_IDLE) && q_valid;
	assign q_pop      = consume;
	assign block_full = q_item.has_byte && (pos == 6'd63);
	assign start_rounds = consume && block_full;

	// Output beat.
	assign m_tvalid = (state_q == sha256_pkg::ST_EMIT);
	assign m_tdata  = {5'b0, emit_idx_q, hash_q[emit_idx_q]};
	assign m_tlast  = (emit_idx_q == 3'd7);

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (consume) begin
					if (block_full) state_d = sha256_pkg::ST_ROUND;
					else if (q_item.last) state_d = sha256_pkg::ST_PAD;
				end
			end
			sha256_pkg::ST_ROUND: begin
				if (round_q == 6'd63) state_d = sha256_pkg::ST_ADD;
			end
			sha256_pkg::ST_ADD: begin
				if (final_q && pad_done_q) state_d = sha256_pkg::ST_EMIT;
				else if (final_q) state_d = sha256_pkg::ST_PAD;
				else state_d = sha256_pkg::ST_IDLE;
			end
			sha256_pkg::ST_PAD: state_d = sha256_pkg::ST_ROUND;
			sha256_pkg::ST_EMIT: begin
				if (m_tready && emit_idx_q == 3'd7) state_d = sha256_pkg::ST_IDLE;
			end
			default: state_d = sha256_pkg::ST_IDLE;
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= sha256_pkg::ST_IDLE;
			round_q    <= '0;
			count_q    <= '0;
			final_q    <= 1'b0;
			pad_done_q <= 1'b0;
			tail_q     <= 1'b0;
			emit_idx_q <= '0;
			for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
		end else begin
			state_q <= state_d;
			case (state_q)
				sha256_pkg::ST_IDLE: begin
					round_q <= '0;
					if (consume) begin
						if (q_item.has_byte) count_q <= count_q + 61'd1;
						final_q    <= q_item.last;
						pad_done_q <= 1'b0;
						tail_q     <= 1'b0;
					end
				end
				sha256_pkg::ST_ROUND: round_q <= round_q + 6'd1;
				sha256_pkg::ST_ADD: begin
					for (int i = 0; i < 8; i++) hash_q[i] <= hash_q[i] + v_q[i];
				end
				sha256_pkg::ST_PAD: begin
					// Second pass over padding always carries the length.
					round_q <= '0;
					if (tail_q || pos < 6'd56) begin
						pad_done_q <= 1'b1;
					end else begin
						pad_done_q <= 1'b0;
						tail_q     <= 1'b1;
					end
				end
				sha256_pkg::ST_EMIT: begin
					if (m_tready) begin
						emit_idx_q <= emit_idx_q + 3'd1;
						if (emit_idx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) hash_q[i] <= sha256_pkg::InitHash[i];
							count_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Block words and round variables; no reset needed on payload.
	always_ff @(posedge clk) begin
		case (state_q)
			sha256_pkg::ST_IDLE: begin
				if (consume && q_item.has_byte) begin
					case (pos[1:0])
						2'd0: w_q[pos[5:2]] <= {q_item.data, 24'h0};
						2'd1: w_q[pos[5:2]][23:16] <= q_item.data;
						2'd2: w_q[pos[5:2]][15:8] <= q_item.data;
						default: w_q[pos[5:2]][7:0] <= q_item.data;
					endcase
				end
				if (start_rounds) begin
					for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
				end
			end
			sha256_pkg::ST_PAD: begin
				for (int i = 0; i < 8; i++) v_q[i] <= hash_q[i];
				if (tail_q) begin
					// Second padding block: zeros plus length.
					for (int i = 0; i < 14; i++) w_q[i] <= '0;
					w_q[14] <= bits[63:32];
					w_q[15] <= bits[31:0];
				end else begin
					// Marker byte, zeros after it, and the length when it still fits.
					for (int i = 0; i < 16; i++) begin
						if (4'(i) == pos[5:2]) begin
							case (pos[1:0])
								2'd0: w_q[i] <= 32'h8000_0000;
								2'd1: w_q[i] <= {w_q[i][31:24], 24'h80_0000};
								2'd2: w_q[i] <= {w_q[i][31:16], 16'h8000};
								default: w_q[i] <= {w_q[i][31:8], 8'h80};
							endcase
						end else if (i == 14 && pos < 6'd56) begin
							w_q[i] <= bits[63:32];
						end else if (i == 15 && pos < 6'd56) begin
							w_q[i] <= bits[31:0];
						end else if (4'(i) > pos[5:2]) begin
							w_q[i] <= '0;
						end
					end
				end
			end
			sha256_pkg::ST_ROUND: begin
				// Schedule advances as a 16-word shift line.
				for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
				w_q[15] <= w_new;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== sv/sha256_message_hasher.sv =====
// A byte that fills a block starts a compression pass: load, 64 rounds, add.
// A last item costs one or two such passes, then eight output beats.
// Other bytes are only stored into the block words; a four-entry queue decouples input from the core.
// Throughput is bounded by the single shared round unit, one round per cycle.
// Asynchronous active-low reset loads the initial hash values and empties the queue.
`default_nettype none
module sha256_message_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // data_byte[7:0]
	input  wire logic        s_tuser,  // byte_valid[0]
	input  wire logic        s_tlast,  // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // digest_word[31:0], word_index[34:32], zero fill
	output logic             m_tlast   // last_word
);

	logic              q_valid;
	logic              q_pop;
	sha256_pkg::item_t q_item;

	// Input classification and queue.
	sha256_front u_front (
		.clk, .arst_n, .s_tvalid, .s_tready, .s_tdata, .s_tuser, .s_tlast,
		.q_valid, .q_pop, .q_item
	);

	// Compression core.
	sha256_core u_core (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.m_tvalid, .m_tready, .m_tdata, .m_tlast
	);

endmodule
`default_nettype wire

// ===== bench/tb_sha256_message_hasher.sv =====
// Self-checking testbench for the streaming SHA-256 message hasher.
`default_nettype none
module tb_sha256_message_hasher;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned IdleLimit = 20000;
	localparam int unsigned DrainCycles = 300;

	// One input beat: byte, byte flag, end-of-message flag and an optional known first digest word.
	typedef struct {
		logic [7:0] data;
		logic       has_byte;
		logic       last;
		logic       check_known;
		logic [31:0] known_word0;
	} stim_row_t;

	// One digest word as it leaves the block.
	typedef struct {
		logic [31:0] word;
		logic [2:0]  index;
		logic        last;
	} digest_beat_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;
	logic        m_tlast;

	sha256_message_hasher u_top (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	// Predictor state.
	logic [31:0]  model_hash [8];
	logic [31:0]  model_block [16];
	logic [60:0]  model_count;
	digest_beat_t expected_digest [$];
	logic [31:0]  pinned_word0 [$];
	int unsigned  error_count;
	int unsigned  idle_cycles;
	int unsigned  send_idle_pct;
	int unsigned  recv_idle_pct;
	logic         recv_hold;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
		return (v >> s) | (v << (32 - s));
	endfunction

	task automatic compress_model();
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++) w[i] = model_block[i];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = model_hash[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::RoundK[r] + w[r];
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) model_hash[i] += v[i];
	endtask

	task automatic place_byte(input int pos, input logic [7:0] b);
		int sh;
		sh = 24 - 8 * (pos % 4);
		if (pos % 4 == 0) begin
			model_block[pos / 4] = 32'(b) << sh;
		end else begin
			model_block[pos / 4] |= 32'(b) << sh;
		end
	endtask

	// Advance the hash model by one accepted beat and queue any digest.
	task automatic hash_accepted_beat(input logic [7:0] b, input logic has_byte, input logic last);
		int pos;
		logic [63:0] bits;
		digest_beat_t d;
		if (has_byte) begin
			place_byte(int'(model_count[5:0]), b);
			model_count = model_count + 1;
			if (model_count[5:0] == 0) compress_model();
		end
		if (last) begin
			pos = int'(model_count[5:0]);
			place_byte(pos, 8'h80);
			for (int i = pos / 4 + 1; i < 16; i++) model_block[i] = '0;
			if (pos >= 56) begin
				compress_model();
				for (int i = 0; i < 16; i++) model_block[i] = '0;
			end
			bits = {model_count, 3'b000};
			model_block[14] = bits[63:32];
			model_block[15] = bits[31:0];
			compress_model();
			for (int i = 0; i < 8; i++) begin
				d.word = model_hash[i];
				d.index = 3'(i);
				d.last = (i == 7);
				expected_digest.insert(expected_digest.size(), d);
			end
			for (int i = 0; i < 8; i++) model_hash[i] = sha256_pkg::InitHash[i];
			model_count = '0;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [39:0] got, input logic [39:0] want);
		$display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// Offer one beat, waiting for acceptance with random gaps; valid stays up afterwards.
	task automatic send_beat(input logic [7:0] b, input logic has_byte, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tuser <= has_byte;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		hash_accepted_beat(b, has_byte, last);
	endtask

	// Drop valid after the last beat of a burst.
	task automatic end_burst();
		s_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_message(input int len, input logic empty_last);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(15) == 0) send_beat(8'($urandom), 1'b0, 1'b0);
			send_beat(8'($urandom), 1'b1, (i == len - 1) && !empty_last);
		end
		if (empty_last || len == 0) send_beat(8'($urandom), 1'b0, 1'b1);
	endtask

	task automatic wait_drained();
		while (expected_digest.size() != 0) @(posedge clk);
	endtask

	// Receiver: random back-pressure plus an optional long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Output checker.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			digest_beat_t want;
			if (expected_digest.size() == 0) begin
				report_mismatch("unexpected beat", m_tdata, '0);
			end else begin
				want = expected_digest.pop_front();
				if (m_tdata[31:0] !== want.word) report_mismatch("digest_word", m_tdata, {8'b0, want.word});
				if (m_tdata[34:32] !== want.index) report_mismatch("word_index", m_tdata, 40'(want.index));
				if (m_tdata[39:35] !== 5'b0) report_mismatch("tdata fill", m_tdata, '0);
				if (m_tlast !== want.last) report_mismatch("tlast", 40'(m_tlast), 40'(want.last));
				if (want.index == 0 && pinned_word0.size() != 0) begin
					if (m_tdata[31:0] !== pinned_word0[0]) report_mismatch("known digest", m_tdata, 40'(pinned_word0[0]));
					void'(pinned_word0.pop_front());
				end
			end
		end
	end

	// Watchdog on cycles without any accepted beat.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [11];
		stim_row_t r;
		int pad_lens [4];
		int len;
		idle_cycles = 0;
		error_count = 0;
		send_idle_pct = 32;
		recv_idle_pct = 53;
		recv_hold = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		s_tlast = 1'b0;
		for (int i = 0; i < 8; i++) model_hash[i] = sha256_pkg::InitHash[i];
		for (int i = 0; i < 16; i++) model_block[i] = '0;
		model_count = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: empty message, "abc", ignored beats, extremes.
		rows = '{
			'{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'hff, 1'b0, 1'b1, 1'b1, 32'he3b0c442},
			'{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},
			'{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h55, 1'b0, 1'b0, 1'b0, 32'h0},
			'{8'haa, 1'b1, 1'b0, 1'b0, 32'h0},
			'{8'h00, 1'b0, 1'b1, 1'b0, 32'h0},
			'{8'hff, 1'b1, 1'b1, 1'b0, 32'h0}
		};
		foreach (rows[i]) begin
			r = rows[i];
			if (r.check_known) pinned_word0.insert(pinned_word0.size(), r.known_word0);
			send_beat(r.data, r.has_byte, r.last);
		end
		end_burst();
		wait_drained();

		// Lengths around the one- and two-block padding boundaries.
		pad_lens = '{55, 56, 63, 64};
		foreach (pad_lens[i]) send_message(pad_lens[i], 1'b0);

		// Long receiver hold while the sender keeps offering beats until the queue fills.
		recv_hold = 1'b1;
		fork
			begin
				repeat (400) @(posedge clk);
				recv_hold = 1'b0;
			end
			begin
				send_message(3, 1'b0);
				send_message(10, 1'b1);
				end_burst();
			end
		join
		wait_drained();

		// Random messages through three idling phases, mostly short.
		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 32 : (phase == 1) ? 53 : 0;
			recv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 32 : 0;
			for (int m = 0; m < 4; m++) begin
				len = ($urandom_range(9) == 0) ? $urandom_range(130, 60) : $urandom_range(12);
				send_message(len, 1'($urandom_range(1)));
			end
			end_burst();
			wait_drained();
		end

		repeat (DrainCycles) @(posedge clk);
		if (error_count == 0 && expected_digest.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
